@@ src/bmg_pkg.sv @@
// ----------------------------------------------------------------------------
// Box-Muller sampler package
// Shared constants, the divisor tables of the Horner steps and the queue
// status bundle.
// ----------------------------------------------------------------------------
package bmg_pkg;

    localparam int UNIFORM_BITS = 53;
    localparam int WORD_W       = 64;
    localparam int SIGMA_W      = 12;
    localparam int SAMPLE_W     = 9;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 12'd819;

    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // Horner step index: 0..4 are the cosine steps, 5..8 the sine steps.
    localparam logic [3:0] K_COS_LAST = 4'd4;
    localparam logic [3:0] K_SIN_LAST = 4'd8;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } bmg_q_status_t;

    // Integer divisor of a Horner step.
    function automatic logic [6:0] horner_div(input logic [3:0] k);
        logic [6:0] d;
        case (k)
            4'd0:    d = 7'd90;
            4'd1:    d = 7'd56;
            4'd2:    d = 7'd30;
            4'd3:    d = 7'd12;
            4'd4:    d = 7'd2;
            4'd5:    d = 7'd72;
            4'd6:    d = 7'd42;
            4'd7:    d = 7'd20;
            4'd8:    d = 7'd6;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the estimate is low by at most one.
    function automatic logic [31:0] horner_recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd0:    r = 32'd47721858;
            4'd1:    r = 32'd76695844;
            4'd2:    r = 32'd143165576;
            4'd3:    r = 32'd357913941;
            4'd4:    r = 32'd2147483648;
            4'd5:    r = 32'd59652323;
            4'd6:    r = 32'd102261126;
            4'd7:    r = 32'd214748364;
            4'd8:    r = 32'd715827882;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

endpackage

@@ src/bmg_queue.sv @@
// ----------------------------------------------------------------------------
// Pair queue
// Two-entry queue of uniform pairs between the front and the back.
// ----------------------------------------------------------------------------
module bmg_queue #(
    parameter int W = 2 * bmg_pkg::UNIFORM_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [W-1:0]           push_data,
    input  logic                   pop,
    output logic [W-1:0]           head_data,
    output bmg_pkg::bmg_q_status_t status
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head_data    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
        else $error("push into full pair queue");

    // The back never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("pop from empty pair queue");

    // The fill count stays within the two entries.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("pair queue count out of range");

endmodule

@@ src/bmg_front.sv @@
// ----------------------------------------------------------------------------
// Sampler front
// Accepts random words, drops zero uniforms and pairs the rest.
// ----------------------------------------------------------------------------
module bmg_front #(
    parameter int UB = bmg_pkg::UNIFORM_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bmg_pkg::WORD_W-1:0]    rand_word,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bmg_pkg::bmg_q_status_t        q_status,
    output logic                          push,
    output logic [2*UB-1:0]               push_data
);

    logic          have_first_reg;
    logic [UB-1:0] first_uniform_reg;
    logic [UB-1:0] uniform;
    logic          accept;
    logic          nonzero;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign uniform  = rand_word[bmg_pkg::WORD_W-1 -: UB];
    assign nonzero  = (uniform != '0);

    // Second uniform of a pair goes to the queue with the first.
    assign push      = accept && nonzero && have_first_reg;
    assign push_data = {first_uniform_reg, uniform};

    always_ff @(posedge clk)
    begin
        if (accept && nonzero && !have_first_reg)
        begin
            first_uniform_reg <= uniform;
        end
    end

    // Pairing flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
        end
        else if (accept && nonzero)
        begin
            have_first_reg <= ~have_first_reg;
        end
    end

endmodule

@@ src/bmg_back.sv @@
// ----------------------------------------------------------------------------
// Sampler back
// Sequencer with one shared multiplier: log2, square root, cosine and sine,
// then the scaling by sigma and the rounding of the sample.
// ----------------------------------------------------------------------------
module bmg_back #(
    parameter int UB = bmg_pkg::UNIFORM_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sigma_we,
    input  logic [bmg_pkg::SIGMA_W-1:0]        sigma_scaled,
    input  bmg_pkg::bmg_q_status_t             q_status,
    input  logic [2*UB-1:0]                    head_data,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bmg_pkg::SAMPLE_W-1:0] noise_sample
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_NORM = 15'b000000000000010,
        ST_LOG  = 15'b000000000000100,
        ST_TMUL = 15'b000000000001000,
        ST_SQRT = 15'b000000000010000,
        ST_ANG  = 15'b000000000100000,
        ST_ASQ  = 15'b000000001000000,
        ST_HMUL = 15'b000000010000000,
        ST_HDIV = 15'b000000100000000,
        ST_HUPD = 15'b000001000000000,
        ST_SMUL = 15'b000010000000000,
        ST_M1   = 15'b000100000000000,
        ST_M2   = 15'b001000000000000,
        ST_M3   = 15'b010000000000000,
        ST_OUT  = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [bmg_pkg::SIGMA_W-1:0] sigma_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  k_reg;
    logic [63:0] w_reg;
    logic [5:0]  lz_reg;
    logic [31:0] ph_reg;
    logic [30:0] x_reg;
    logic [23:0] fr_reg;
    logic [63:0] sq_v_reg;
    logic [63:0] sq_res_reg;
    logic        fold_reg;
    logic [29:0] a_reg;
    logic [29:0] a2_reg;
    logic [30:0] t_reg;
    logic [29:0] q_reg;
    logic [29:0] est_reg;
    logic [24:0] ca_reg;
    logic [24:0] cmag_reg;
    logic        neg_reg;
    logic [52:0] p1_reg;
    logic [65:0] acc_reg;
    logic        out_valid_reg;
    logic [bmg_pkg::SAMPLE_W-1:0] sample_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // Negative log2 in Q.24 from the leading-zero count and the fraction bits.
    function automatic logic [29:0] lz_plus_l();
        logic [5:0] lzp;
        lzp = lz_reg + 6'd1;
        return {lzp, 24'd0} - {6'd0, fr_reg};
    endfunction

    // Phase folded into the first half of a quarter turn.
    function automatic logic [29:0] fold_angle();
        logic [29:0] f;
        f = ph_reg[29:0];
        return (f > 30'h2000_0000) ? (30'h0 - f) : f;
    endfunction

    // Shared multiplier, operands chosen by state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOG:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            ST_TMUL:
            begin
                mul_a = {2'b0, lz_plus_l()};
                mul_b = bmg_pkg::TWO_LN2_Q30;
            end
            ST_ANG:
            begin
                mul_a = {2'b0, fold_angle()};
                mul_b = bmg_pkg::HALF_PI_Q30;
            end
            ST_ASQ:
            begin
                mul_a = {2'b0, a_reg};
                mul_b = {2'b0, a_reg};
            end
            ST_HMUL:
            begin
                mul_a = {2'b0, a2_reg};
                mul_b = {1'b0, t_reg};
            end
            ST_HDIV:
            begin
                mul_a = {2'b0, q_reg};
                mul_b = bmg_pkg::horner_recip(k_reg);
            end
            ST_SMUL:
            begin
                mul_a = {2'b0, a_reg};
                mul_b = {1'b0, t_reg};
            end
            ST_M1:
            begin
                mul_a = sq_res_reg[31:0];
                mul_b = {7'b0, cmag_reg};
            end
            ST_M2:
            begin
                mul_a = {20'b0, sigma_reg};
                mul_b = p1_reg[31:0];
            end
            ST_M3:
            begin
                mul_a = {20'b0, sigma_reg};
                mul_b = {11'b0, p1_reg[52:32]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // Normalizing step: shift by 32, 16, 8, 4, 2, 1 when those top bits are zero.
    logic [6:0]  norm_sh;
    logic        norm_zero;
    logic [63:0] w_shifted;
    logic [5:0]  lz_shifted;

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    norm_sh = 7'd32;
            3'd1:    norm_sh = 7'd16;
            3'd2:    norm_sh = 7'd8;
            3'd3:    norm_sh = 7'd4;
            3'd4:    norm_sh = 7'd2;
            default: norm_sh = 7'd1;
        endcase
        norm_zero  = ((w_reg >> (7'd64 - norm_sh)) == 64'd0);
        w_shifted  = norm_zero ? (w_reg << norm_sh) : w_reg;
        lz_shifted = norm_zero ? (lz_reg + norm_sh[5:0]) : lz_reg;
    end

    // Squaring step of the log2 and the rounded T for the square root.
    logic [31:0] log_y;
    logic [63:0] t_round;

    assign log_y   = prod[61:30];
    assign t_round = (prod + 64'h2000_0000) >> 30;

    // Square root step.
    logic [63:0] sq_bit;
    logic [63:0] sq_trial;

    assign sq_bit   = 64'd1 << (7'd62 - {1'b0, cnt_reg, 1'b0});
    assign sq_trial = sq_res_reg + sq_bit;

    // Division of the Horner product by a constant, with one correction.
    logic [6:0]  h_div;
    logic [36:0] h_back;
    logic [36:0] h_rem;
    logic [30:0] h_quot;
    logic [30:0] t_new;
    logic [24:0] t_q24;

    always_comb
    begin
        h_div  = bmg_pkg::horner_div(k_reg);
        h_back = {7'd0, est_reg} * {30'd0, h_div};
        h_rem  = {7'd0, q_reg} - h_back;
        h_quot = {1'b0, est_reg} + ((h_rem >= {30'd0, h_div}) ? 31'd1 : 31'd0);
        t_new  = bmg_pkg::ONE_Q30[30:0] - h_quot;
        t_q24  = 25'((t_new + 31'd32) >> 6);
    end

    // Sine rounding and the quadrant selection.
    logic [29:0] s_q30;
    logic [24:0] sa_now;
    logic [24:0] c_cos;
    logic [24:0] c_sin;

    always_comb
    begin
        s_q30  = prod[59:30];
        sa_now = 25'(({1'b0, s_q30} + 31'd32) >> 6);
        c_cos  = fold_reg ? sa_now : ca_reg;
        c_sin  = fold_reg ? ca_reg : sa_now;
    end

    // Rounding and saturation of the sample.
    logic [9:0]                   mag;
    logic [bmg_pkg::SAMPLE_W-1:0] sample_now;

    always_comb
    begin
        mag = 10'((acc_reg + 66'h80_0000_0000_0000) >> 56);
        if (neg_reg)
        begin
            sample_now = (mag > 10'd256) ? 9'h100 : 9'((~mag) + 10'd1);
        end
        else
        begin
            sample_now = (mag > 10'd255) ? 9'h0FF : mag[8:0];
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_NORM;
            ST_NORM: if (cnt_reg == 5'd5) state_next = ST_LOG;
            ST_LOG:  if (cnt_reg == 5'd23) state_next = ST_TMUL;
            ST_TMUL: state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 5'd31) state_next = ST_ANG;
            ST_ANG:  state_next = ST_ASQ;
            ST_ASQ:  state_next = ST_HMUL;
            ST_HMUL: state_next = ST_HDIV;
            ST_HDIV: state_next = ST_HUPD;
            ST_HUPD: state_next = (k_reg == bmg_pkg::K_SIN_LAST) ? ST_SMUL : ST_HMUL;
            ST_SMUL: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            k_reg         <= 4'd0;
            sigma_reg     <= bmg_pkg::SIGMA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sigma_we)
            begin
                sigma_reg <= sigma_scaled;
            end
            if ((state_reg != state_next) || (state_reg == ST_IDLE))
            begin
                cnt_reg <= 5'd0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            if (state_reg == ST_ASQ)
            begin
                k_reg <= 4'd0;
            end
            else if (state_reg == ST_HUPD)
            begin
                k_reg <= k_reg + 4'd1;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                w_reg  <= {head_data[2*UB-1:UB], {(64-UB){1'b0}}};
                ph_reg <= 32'({head_data[UB-1:0], {(64-UB){1'b0}}} >> 32);
                lz_reg <= 6'd0;
            end
            ST_NORM:
            begin
                w_reg  <= w_shifted;
                lz_reg <= lz_shifted;
                x_reg  <= w_shifted[63:33];
                fr_reg <= 24'd0;
            end
            ST_LOG:
            begin
                x_reg  <= log_y[31] ? log_y[31:1] : log_y[30:0];
                fr_reg <= {fr_reg[22:0], log_y[31]};
            end
            ST_TMUL:
            begin
                sq_v_reg   <= t_round << 24;
                sq_res_reg <= 64'd0;
            end
            ST_SQRT:
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_reg   <= sq_v_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
            end
            ST_ANG:
            begin
                a_reg    <= prod[59:30];
                fold_reg <= (ph_reg[29:0] > 30'h2000_0000);
            end
            ST_ASQ:
            begin
                a2_reg <= prod[59:30];
                t_reg  <= bmg_pkg::ONE_Q30[30:0];
            end
            ST_HMUL:
            begin
                q_reg <= prod[59:30];
            end
            ST_HDIV:
            begin
                est_reg <= prod[61:32];
            end
            ST_HUPD:
            begin
                if (k_reg == bmg_pkg::K_COS_LAST)
                begin
                    ca_reg <= t_q24;
                    t_reg  <= bmg_pkg::ONE_Q30[30:0];
                end
                else
                begin
                    t_reg <= t_new;
                end
            end
            ST_SMUL:
            begin
                case (ph_reg[31:30])
                    2'd0:
                    begin
                        cmag_reg <= c_cos;
                        neg_reg  <= 1'b0;
                    end
                    2'd1:
                    begin
                        cmag_reg <= c_sin;
                        neg_reg  <= 1'b1;
                    end
                    2'd2:
                    begin
                        cmag_reg <= c_cos;
                        neg_reg  <= 1'b1;
                    end
                    default:
                    begin
                        cmag_reg <= c_sin;
                        neg_reg  <= 1'b0;
                    end
                endcase
            end
            ST_M1:
            begin
                p1_reg <= prod[52:0];
            end
            ST_M2:
            begin
                acc_reg <= {2'b0, prod};
            end
            ST_M3:
            begin
                acc_reg <= acc_reg + {prod[33:0], 32'd0};
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    sample_reg <= sample_now;
                end
            end
            default:
            begin
                w_reg <= w_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign noise_sample = sample_reg;

    // A pair leaves the queue only when the sequencer starts on it.
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (state_reg == ST_NORM))
        else $error("pair popped outside idle");

    // A new sample never overwrites one that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(sample_reg))
        else $error("stalled sample overwritten");

    // The Horner index never goes beyond one past the last sine step.
    assert property (@(posedge clk) disable iff (!rst_n) k_reg <= 4'd9)
        else $error("Horner index out of range");

endmodule

@@ src/box_muller_gaussian_sampler.sv @@
// Order: the pair entering the back is normalized, then come the log2, the
// square root, the Horner steps, the multiplies and the output.
// Flow: the shared-multiplier sequencer takes a new pair only once it is idle;
// words are taken one per cycle while the two-entry pair queue has room.
// Reset: asynchronous, active low; clears pairing, queue and sequencer and
// loads the sigma register with 819.
// ----------------------------------------------------------------------------
// Box-Muller gaussian sampler
// Front pairs nonzero uniforms, a short queue decouples it from the back
// sequencer that computes the rounded gaussian deviate.
// ----------------------------------------------------------------------------
module box_muller_gaussian_sampler #(
    parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sigma_we,
    input  logic [bmg_pkg::SIGMA_W-1:0]         sigma_scaled,
    input  logic [bmg_pkg::WORD_W-1:0]          rand_word,
    input  logic                                in_valid,
    output logic                                in_stall,
    output logic signed [bmg_pkg::SAMPLE_W-1:0] noise_sample,
    output logic                                out_valid,
    input  logic                                out_stall
);

    bmg_pkg::bmg_q_status_t    q_status;
    logic                      push;
    logic                      pop;
    logic [2*UNIFORM_BITS-1:0] push_data;
    logic [2*UNIFORM_BITS-1:0] head_data;

    // Pairing front.
    bmg_front #(
        .UB(UNIFORM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rand_word (rand_word),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Pair queue.
    bmg_queue #(
        .W(2 * UNIFORM_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    // Arithmetic back.
    bmg_back #(
        .UB(UNIFORM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sigma_we     (sigma_we),
        .sigma_scaled (sigma_scaled),
        .q_status     (q_status),
        .head_data    (head_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .noise_sample (noise_sample)
    );

endmodule
